/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SILU_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define SILU_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define SILU_ASSERT(lbl, clk, rst, prop)

`define SILU_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

/* sv/silu_pkg.sv */
// ----------------------------------------------------------------------------
// SiLU package
// Single-precision arithmetic helpers, constants and the per-step context
// carried along the activation pipeline.
// ----------------------------------------------------------------------------
package silu_pkg;

   localparam int STEP_COUNT = 19;
   localparam int DIV_ITERS  = 27;
   localparam int DIV_LAT    = DIV_ITERS + 2;
   localparam int PIPE_DEPTH = 2 * STEP_COUNT + DIV_LAT;

   localparam logic [31:0] FP_ZERO    = 32'h0000_0000;
   localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
   localparam logic [31:0] FP_HALF    = 32'h3F00_0000;
   localparam logic [31:0] FP_QUARTER = 32'h3E80_0000;
   localparam logic [31:0] FP_INF     = 32'h7F80_0000;
   localparam logic [31:0] FP_CANON   = 32'h7FC0_0000;
   localparam logic [31:0] C_NEG_LN2  = 32'hBF31_7218;
   localparam logic [31:0] C_INV_LN2  = 32'h3FB8_AA3B;
   localparam logic [31:0] C_MAGIC    = 32'h4B40_0000;
   localparam logic [31:0] C_NMAGIC   = 32'hCB40_0000;
   localparam logic [31:0] C_H3       = 32'h3E2A_AAAB;
   localparam logic [31:0] C_H4       = 32'h3D2A_AAAB;
   localparam logic [31:0] C_H5       = 32'h3C08_8889;
   localparam logic [31:0] C_H6       = 32'h3AB6_0B61;
   localparam logic [31:0] C_P3       = 32'hBCAA_AAAB;
   localparam logic [31:0] C_P5       = 32'h3B08_8889;
   localparam logic [31:0] C_P7       = 32'hB95D_0DD1;
   localparam logic [31:0] C_P9       = 32'h37B3_27A4;
   localparam logic [30:0] MAG_127    = 31'h42FE_0000;
   localparam logic [30:0] MAG_126    = 31'h42FC_0000;
   localparam logic [7:0]  EXP_BIAS   = 8'd127;

   // Unrounded result: value = mant * 2^(exp - 127 - 46).
   typedef struct packed {
      logic               nan;
      logic               inf;
      logic               zero;
      logic               sign;
      logic signed [11:0] exp;
      logic [47:0]        mant;
   } fp_raw_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] num;
      logic [31:0] den;
      logic [31:0] e0;
      logic [31:0] b0;
      logic [31:0] x2;
      logic [31:0] xp;
      logic [31:0] s1;
      logic [31:0] t1;
      logic [7:0]  efield;
      logic        ovf;
      logic        unf;
      logic        mode;
      logic        last;
   } ctx_type;

   typedef struct packed {
      logic [31:0] m0a;
      logic [31:0] m0b;
      logic [31:0] m1a;
      logic [31:0] m1b;
      logic [31:0] m2a;
      logic [31:0] m2b;
      logic [31:0] a0a;
      logic [31:0] a0b;
      logic [31:0] a1a;
      logic [31:0] a1b;
   } ops_type;

   function automatic logic [5:0] lead_pos48(input logic [47:0] v);
      logic [5:0] p;
      p = '0;
      for (int i = 0; i < 48; i++) begin
         if (v[i]) begin
            p = 6'(i);
         end
      end
      return p;
   endfunction

   function automatic logic [4:0] lead_pos24(input logic [23:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < 24; i++) begin
         if (v[i]) begin
            p = 5'(i);
         end
      end
      return p;
   endfunction

   function automatic logic is_nan(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] != '0);
   endfunction

   function automatic logic is_inf(input logic [31:0] a);
      return (a[30:23] == 8'hFF) && (a[22:0] == '0);
   endfunction

   function automatic logic is_zero(input logic [31:0] a);
      return a[30:0] == '0;
   endfunction

   function automatic logic [7:0] eff_exp(input logic [31:0] a);
      return (a[30:23] == '0) ? 8'd1 : a[30:23];
   endfunction

   function automatic fp_raw_type fp_mul_raw(input logic [31:0] a, input logic [31:0] b);
      fp_raw_type r;
      logic [23:0] ma;
      logic [23:0] mb;
      ma = {a[30:23] != '0, a[22:0]};
      mb = {b[30:23] != '0, b[22:0]};
      r.sign = a[31] ^ b[31];
      r.nan  = is_nan(a) | is_nan(b) | (is_inf(a) & is_zero(b)) | (is_inf(b) & is_zero(a));
      r.inf  = !r.nan & (is_inf(a) | is_inf(b));
      r.zero = !r.nan & !r.inf & (is_zero(a) | is_zero(b));
      r.exp  = $signed({4'd0, eff_exp(a)}) + $signed({4'd0, eff_exp(b)})
               - $signed({4'd0, EXP_BIAS});
      r.mant = ma * mb;
      return r;
   endfunction

   function automatic fp_raw_type fp_add_raw(input logic [31:0] a, input logic [31:0] b);
      fp_raw_type  r;
      logic [31:0] big;
      logic [31:0] sml;
      logic [7:0]  d;
      logic [5:0]  sh;
      logic [47:0] bfull;
      logic [47:0] sfull;
      logic [95:0] wide;
      logic [47:0] sal;
      logic [47:0] sum;
      big   = (b[30:0] > a[30:0]) ? b : a;
      sml   = (b[30:0] > a[30:0]) ? a : b;
      d     = eff_exp(big) - eff_exp(sml);
      sh    = (d > 8'd63) ? 6'd63 : d[5:0];
      bfull = {1'b0, big[30:23] != '0, big[22:0], 23'd0};
      sfull = {1'b0, sml[30:23] != '0, sml[22:0], 23'd0};
      wide  = {sfull, 48'd0} >> sh;
      // Bits shifted out below the window are folded into a sticky bit.
      sal   = wide[95:48] | {47'd0, |wide[47:0]};
      sum   = (big[31] ^ sml[31]) ? (bfull - sal) : (bfull + sal);
      r.nan  = is_nan(a) | is_nan(b) | (is_inf(a) & is_inf(b) & (a[31] != b[31]));
      r.inf  = !r.nan & (is_inf(a) | is_inf(b));
      r.zero = !r.nan & !r.inf & (sum == '0);
      r.exp  = $signed({4'd0, eff_exp(big)});
      r.mant = sum;
      if (r.inf) begin
         r.sign = is_inf(a) ? a[31] : b[31];
      end else if (sum == '0) begin
         r.sign = a[31] & b[31];
      end else begin
         r.sign = big[31];
      end
      return r;
   endfunction

   function automatic logic [31:0] fp_round(input fp_raw_type r);
      logic [5:0]         lz;
      logic [47:0]        norm;
      logic [47:0]        norm2;
      logic [95:0]        wide;
      logic signed [11:0] en;
      logic [5:0]         sh;
      logic               stk;
      logic               st;
      logic               up;
      logic [23:0]        sig;
      logic [7:0]         efb;
      logic [30:0]        tot;
      logic [31:0]        res;
      lz    = 6'd47 - lead_pos48(r.mant);
      norm  = r.mant << lz;
      en    = r.exp + 12'sd1 - $signed({6'd0, lz});
      norm2 = norm;
      stk   = 1'b0;
      efb   = 8'(en - 12'sd1);
      wide  = '0;
      sh    = '0;
      if (en <= 12'sd0) begin
         // Subnormal result: denormalise before rounding.
         sh    = (en < -12'sd62) ? 6'd63 : 6'(12'sd1 - en);
         wide  = {norm, 48'd0} >> sh;
         norm2 = wide[95:48];
         stk   = |wide[47:0];
         efb   = '0;
      end
      sig = norm2[47:24];
      st  = (|norm2[22:0]) | stk;
      up  = norm2[23] & (st | sig[0]);
      // A carry out of the significand moves into the exponent field.
      tot = {efb, 23'd0} + {7'd0, sig} + {30'd0, up};
      priority if (r.nan) begin
         res = FP_CANON;
      end else if (r.inf || (!r.zero && r.mant != '0 && en > 12'sd254)) begin
         res = {r.sign, FP_INF[30:0]};
      end else if (r.zero || r.mant == '0) begin
         res = {r.sign, 31'd0};
      end else begin
         res = {r.sign, tot};
      end
      return res;
   endfunction

   function automatic ops_type step_operands(input int k, input ctx_type c);
      ops_type     o;
      logic [31:0] tneg;
      logic [31:0] esel;
      o    = '0;
      tneg = {~c.x[31], c.x[30:0]};
      esel = c.ovf ? FP_INF : (c.unf ? FP_ZERO : c.e0);
      unique case (k)
         1: begin
            o.m0a = tneg;       o.m0b = C_INV_LN2;
            o.m1a = c.x;        o.m1b = c.x;
            o.m2a = FP_QUARTER; o.m2b = c.x;
         end
         2: begin
            o.a0a = c.e0;       o.a0b = C_MAGIC;
            o.m1a = c.x;        o.m1b = c.x2;
            o.a1a = FP_HALF;    o.a1b = c.t1;
         end
         3: begin
            o.a0a = c.e0;       o.a0b = C_NMAGIC;
            o.m1a = c.xp;       o.m1b = c.x2;
            o.m2a = C_P3;       o.m2b = c.xp;
         end
         4: begin
            o.m0a = C_NEG_LN2;  o.m0b = c.e0;
            o.a1a = c.s1;       o.a1b = c.t1;
            o.m2a = C_P5;       o.m2b = c.xp;
            o.m1a = c.xp;       o.m1b = c.x2;
         end
         5: begin
            o.a0a = tneg;       o.a0b = c.e0;
            o.a1a = c.s1;       o.a1b = c.t1;
            o.m2a = C_P7;       o.m2b = c.xp;
            o.m1a = c.xp;       o.m1b = c.x2;
         end
         6: begin
            o.m0a = C_H6;       o.m0b = c.b0;
            o.a1a = c.s1;       o.a1b = c.t1;
            o.m2a = C_P9;       o.m2b = c.xp;
         end
         7: begin
            o.a0a = c.e0;       o.a0b = C_H5;
            o.a1a = c.s1;       o.a1b = c.t1;
         end
         8: begin
            o.m0a = c.e0;       o.m0b = c.b0;
            o.m1a = c.x;        o.m1b = c.s1;
         end
         10, 12, 14, 16: begin
            o.m0a = c.e0;       o.m0b = c.b0;
         end
         9:  begin o.a0a = c.e0; o.a0b = C_H4;    end
         11: begin o.a0a = c.e0; o.a0b = C_H3;    end
         13: begin o.a0a = c.e0; o.a0b = FP_HALF; end
         15, 17: begin o.a0a = c.e0; o.a0b = FP_ONE; end
         18: begin
            o.m0a = {1'b0, c.efield, 23'd0};
            o.m0b = c.e0;
         end
         19: begin
            o.a0a = esel;       o.a0b = FP_ONE;
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   function automatic ctx_type step_update(input int k, input ctx_type c,
                                           input logic [31:0] rm0, input logic [31:0] rm1,
                                           input logic [31:0] rm2, input logic [31:0] ra0,
                                           input logic [31:0] ra1);
      ctx_type     n;
      logic        a_nan;
      logic [23:0] ma;
      logic [7:0]  amt;
      logic [7:0]  mag;
      n     = c;
      a_nan = is_nan(c.e0);
      ma    = {1'b1, c.e0[22:0]};
      amt   = 8'd150 - c.e0[30:23];
      mag   = (c.e0[30:23] < EXP_BIAS) ? 8'd0 : 8'(ma >> amt);
      unique case (k)
         1: begin n.e0 = rm0; n.x2 = rm1; n.t1 = rm2; end
         2: begin n.e0 = ra0; n.xp = rm1; n.s1 = ra1; end
         3: begin n.e0 = ra0; n.xp = rm1; n.t1 = rm2; end
         4: begin
            // The rounded exponent decides saturation and builds 2^a.
            n.ovf    = a_nan | (!c.e0[31] && c.e0[30:0] > MAG_127);
            n.unf    = !a_nan && c.e0[31] && c.e0[30:0] > MAG_126;
            n.efield = c.e0[31] ? (EXP_BIAS - mag) : (EXP_BIAS + mag);
            n.e0 = rm0; n.s1 = ra1; n.t1 = rm2; n.xp = rm1;
         end
         5: begin n.b0 = ra0; n.s1 = ra1; n.t1 = rm2; n.xp = rm1; end
         6: begin n.e0 = rm0; n.s1 = ra1; n.t1 = rm2; end
         7: begin n.e0 = ra0; n.s1 = ra1; end
         8: begin n.e0 = rm0; n.num = rm1; end
         9, 11, 13, 15, 17: begin n.e0 = ra0; end
         10, 12, 14, 16, 18: begin n.e0 = rm0; end
         19: begin
            n.num = c.mode ? c.num : c.x;
            n.den = c.mode ? FP_ONE : ra0;
         end
         default: begin
         end
      endcase
      return n;
   endfunction

endpackage

/* sv/silu_fp_step.sv */
// ----------------------------------------------------------------------------
// SiLU arithmetic step
// One two-stage slice of the pipeline: multiply or align-and-add in the first
// stage, normalise and round in the second, with the context carried along.
// ----------------------------------------------------------------------------
module silu_fp_step #(
   parameter int STEP = 1
) (
   input  logic              clock,
   input  logic              en,
   input  silu_pkg::ctx_type ctx_in,
   output silu_pkg::ctx_type ctx_out
);
   import silu_pkg::*;

   ops_type    ops;
   ctx_type    ctx_mid_in, ctx_mid_ff;
   fp_raw_type m0_in, m0_ff;
   fp_raw_type m1_in, m1_ff;
   fp_raw_type m2_in, m2_ff;
   fp_raw_type a0_in, a0_ff;
   fp_raw_type a1_in, a1_ff;
   ctx_type    ctx_out_in, ctx_out_ff;

   always_comb begin
      ops        = step_operands(STEP, ctx_in);
      ctx_mid_in = ctx_in;
      m0_in      = fp_mul_raw(ops.m0a, ops.m0b);
      m1_in      = fp_mul_raw(ops.m1a, ops.m1b);
      m2_in      = fp_mul_raw(ops.m2a, ops.m2b);
      a0_in      = fp_add_raw(ops.a0a, ops.a0b);
      a1_in      = fp_add_raw(ops.a1a, ops.a1b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_mid_ff <= ctx_mid_in;
         m0_ff      <= m0_in;
         m1_ff      <= m1_in;
         m2_ff      <= m2_in;
         a0_ff      <= a0_in;
         a1_ff      <= a1_in;
      end
   end

   always_comb begin
      ctx_out_in = step_update(STEP, ctx_mid_ff, fp_round(m0_ff), fp_round(m1_ff),
                               fp_round(m2_ff), fp_round(a0_ff), fp_round(a1_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_out_ff <= ctx_out_in;
      end
   end

   assign ctx_out = ctx_out_ff;

endmodule

/* sv/silu_fp_div.sv */
// ----------------------------------------------------------------------------
// SiLU divider
// Pipelined single-precision division: operand normalisation, one restoring
// quotient bit per stage, then a rounding stage.
// ----------------------------------------------------------------------------
module silu_fp_div (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] num,
   input  logic [31:0] den,
   input  logic        last_in,
   output logic [31:0] result_bits,
   output logic        last_out
);
   import silu_pkg::*;

   typedef struct packed {
      logic               nan;
      logic               inf;
      logic               zero;
      logic               sign;
      logic signed [11:0] exp;
      logic [24:0]        rem;
      logic [23:0]        md;
      logic [DIV_ITERS-1:0] q;
      logic               last;
   } div_stage_type;

   div_stage_type stg_in [0:DIV_ITERS];
   div_stage_type stg_ff [0:DIV_ITERS];
   fp_raw_type    fin;
   logic [31:0]   result_in, result_ff;
   logic          last_ff;
   logic [4:0]    lzx, lzd;

   always_comb begin
      lzx = 5'd23 - lead_pos24({num[30:23] != '0, num[22:0]});
      lzd = 5'd23 - lead_pos24({den[30:23] != '0, den[22:0]});
      stg_in[0].sign = num[31] ^ den[31];
      stg_in[0].nan  = is_nan(num) | is_nan(den) | (is_inf(num) & is_inf(den))
                       | (is_zero(num) & is_zero(den));
      stg_in[0].inf  = !stg_in[0].nan & (is_inf(num) | is_zero(den));
      stg_in[0].zero = !stg_in[0].nan & !stg_in[0].inf & (is_zero(num) | is_inf(den));
      stg_in[0].exp  = $signed({4'd0, eff_exp(num)}) - $signed({7'd0, lzx})
                       - $signed({4'd0, eff_exp(den)}) + $signed({7'd0, lzd})
                       + $signed({4'd0, EXP_BIAS});
      stg_in[0].rem  = {1'b0, {num[30:23] != '0, num[22:0]} << lzx};
      stg_in[0].md   = {den[30:23] != '0, den[22:0]} << lzd;
      stg_in[0].q    = '0;
      stg_in[0].last = last_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stg_ff[0] <= stg_in[0];
      end
   end

   for (genvar i = 0; i < DIV_ITERS; i++) begin : g_iter
      logic        ge;
      logic [24:0] diff;
      always_comb begin
         ge   = stg_ff[i].rem >= {1'b0, stg_ff[i].md};
         diff = stg_ff[i].rem - {1'b0, stg_ff[i].md};
         stg_in[i+1]     = stg_ff[i];
         stg_in[i+1].rem = {(ge ? diff[23:0] : stg_ff[i].rem[23:0]), 1'b0};
         stg_in[i+1].q   = {stg_ff[i].q[DIV_ITERS-2:0], ge};
      end
      always_ff @(posedge clock) begin
         if (en) begin
            stg_ff[i+1] <= stg_in[i+1];
         end
      end
   end

   always_comb begin
      fin.nan   = stg_ff[DIV_ITERS].nan;
      fin.inf   = stg_ff[DIV_ITERS].inf;
      fin.zero  = stg_ff[DIV_ITERS].zero;
      fin.sign  = stg_ff[DIV_ITERS].sign;
      fin.exp   = stg_ff[DIV_ITERS].exp;
      // Leading quotient bit sits at the unit position; the remainder is sticky.
      fin.mant  = {1'b0, stg_ff[DIV_ITERS].q, |stg_ff[DIV_ITERS].rem,
                   (46 - DIV_ITERS)'(0)};
      result_in = fp_round(fin);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
         last_ff   <= stg_ff[DIV_ITERS].last;
      end
   end

   assign result_bits = result_ff;
   assign last_out    = last_ff;

endmodule

/* sv/silu_activation_core.sv */
// ----------------------------------------------------------------------------
// SiLU activation core
// Streams IEEE single-precision samples through x*sigmoid(x), using either an
// exponential with a final division or a ninth-order sigmoid polynomial.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                   | Handshake
//  ---------+-----------------------------------------+-----------------
//  request  | req_sample_bits, req_last_in            | req_valid/ready
//  response | rsp_result_bits, rsp_last_out           | rsp_valid/ready
//  csr      | csr_write_data                          | csr_write_enable
//
// One transaction enters per cycle unless the pipeline stalls; it passes through
// 19 two-stage arithmetic steps, then a 29-stage divider (27 quotient stages).
// Reset clears the valid bits and selects the exponential form.
// A response held by a low rsp_ready freezes the whole pipeline, so nothing is
// dropped or repeated; req_ready falls only in that case.
`include "assert_macros.svh"

module silu_activation_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_sample_bits,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_result_bits,
   output logic        rsp_last_out,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   import silu_pkg::*;

   logic                  method_in, method_ff;
   logic [PIPE_DEPTH-1:0] vld_in, vld_ff;
   logic                  pipe_en;
   ctx_type               ctx_w [0:STEP_COUNT];

   always_comb begin
      method_in = csr_write_enable ? csr_write_data : method_ff;
      pipe_en   = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
      vld_in    = pipe_en ? {vld_ff[PIPE_DEPTH-2:0], req_valid} : vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= 1'b0;
         vld_ff    <= '0;
      end else begin
         method_ff <= method_in;
         vld_ff    <= vld_in;
      end
   end

   always_comb begin
      ctx_w[0]      = '0;
      ctx_w[0].x    = req_sample_bits;
      ctx_w[0].last = req_last_in;
      ctx_w[0].mode = method_ff;
   end

   for (genvar k = 0; k < STEP_COUNT; k++) begin : g_step
      silu_fp_step #(
         .STEP (k + 1)
      ) u_step (
         .clock   (clock),
         .en      (pipe_en),
         .ctx_in  (ctx_w[k]),
         .ctx_out (ctx_w[k+1])
      );
   end

   silu_fp_div u_div (
      .clock       (clock),
      .en          (pipe_en),
      .num         (ctx_w[STEP_COUNT].num),
      .den         (ctx_w[STEP_COUNT].den),
      .last_in     (ctx_w[STEP_COUNT].last),
      .result_bits (rsp_result_bits),
      .last_out    (rsp_last_out)
   );

   assign req_ready = pipe_en;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   `SILU_ASSERT(a_accept_enters, clock, reset, (req_valid && req_ready) |=> vld_ff[0])
   `SILU_ASSERT(a_stall_freezes, clock, reset, (rsp_valid && !rsp_ready) |=> $stable(vld_ff))
   `SILU_ASSERT(a_csr_written, clock, reset, csr_write_enable |=> method_ff == $past(csr_write_data))
   `SILU_ASSERT_NEVER(a_no_idle_block, clock, reset, !req_ready && !rsp_valid)

endmodule

/* test/silu_activation_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SiLU activation checker
// Watches the request, response and register ports of the SiLU core, works
// out the single-precision result of every accepted request and compares it,
// in order, with the responses that leave the core.
// ----------------------------------------------------------------------------
module silu_activation_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_sample_bits,
   input  logic        req_last_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_result_bits,
   input  logic        rsp_last_out,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   output int          fail_count,
   output int          pending_count
);
   import silu_pkg::*;

   typedef struct {
      bit              sgn;
      int              ex;
      longint unsigned man;
      bit              is_nan;
      bit              is_inf;
      bit              is_zero;
   } float_parts_type;

   typedef struct {
      logic [31:0] result_bits;
      logic        last_out;
   } silu_result_type;

   silu_result_type awaited_results[$];
   logic            poly_mode;

   assign pending_count = awaited_results.size();

   // Value is man * 2^ex, with the significand normalised to bit 23.
   function automatic float_parts_type split_float(input logic [31:0] f);
      float_parts_type p;
      p.sgn     = f[31];
      p.is_nan  = (f[30:23] == 8'hFF) && (f[22:0] != '0);
      p.is_inf  = (f[30:23] == 8'hFF) && (f[22:0] == '0);
      p.is_zero = (f[30:0] == '0);
      p.man     = (f[30:23] != '0) ? {40'd0, 1'b1, f[22:0]} : {41'd0, f[22:0]};
      p.ex      = ((f[30:23] != '0) ? int'(f[30:23]) : 1) - 150;
      if (!p.is_zero) begin
         while (!p.man[23]) begin
            p.man = p.man << 1;
            p.ex  = p.ex - 1;
         end
      end
      return p;
   endfunction

   // Rounds sgn * man * 2^ex to nearest even and packs it as a single.
   function automatic logic [31:0] round_pack(input bit sgn, input int ex,
                                              input longint unsigned man);
      int              msb;
      int              q;
      int              sh;
      longint unsigned kept;
      longint unsigned rem;
      longint unsigned half;
      bit              up;
      longint          bits;
      if (man == 0) begin
         return {sgn, 31'd0};
      end
      msb = 63;
      while (!man[msb]) begin
         msb = msb - 1;
      end
      q = msb + ex - 23;
      if (q < -149) begin
         q = -149;
      end
      sh = q - ex;
      up = 1'b0;
      if (sh <= 0) begin
         kept = man << (-sh);
      end else if (sh >= 64) begin
         kept = 0;
      end else begin
         kept = man >> sh;
         rem  = man & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         up   = (rem > half) || (rem == half && kept[0]);
      end
      kept = kept + up;
      // A subnormal that rounds up to 2^23 becomes the smallest normal here.
      bits = (longint'(q + 149) <<< 23) + longint'(kept);
      if (bits >= 64'sh7F80_0000) begin
         return {sgn, 8'hFF, 23'd0};
      end
      return {sgn, bits[30:0]};
   endfunction

   function automatic logic [31:0] float_mul(input logic [31:0] a, input logic [31:0] b);
      float_parts_type pa;
      float_parts_type pb;
      pa = split_float(a);
      pb = split_float(b);
      if (pa.is_nan || pb.is_nan || (pa.is_inf && pb.is_zero) || (pb.is_inf && pa.is_zero))
      begin
         return FP_CANON;
      end
      if (pa.is_inf || pb.is_inf) begin
         return {pa.sgn ^ pb.sgn, 8'hFF, 23'd0};
      end
      if (pa.is_zero || pb.is_zero) begin
         return {pa.sgn ^ pb.sgn, 31'd0};
      end
      return round_pack(pa.sgn ^ pb.sgn, pa.ex + pb.ex, pa.man * pb.man);
   endfunction

   function automatic logic [31:0] float_add(input logic [31:0] a, input logic [31:0] b);
      float_parts_type pa;
      float_parts_type pb;
      float_parts_type big;
      float_parts_type sml;
      int              d;
      longint unsigned mbig;
      longint unsigned msml;
      longint unsigned sum;
      pa = split_float(a);
      pb = split_float(b);
      if (pa.is_nan || pb.is_nan || (pa.is_inf && pb.is_inf && pa.sgn != pb.sgn)) begin
         return FP_CANON;
      end
      if (pa.is_inf) begin
         return a;
      end
      if (pb.is_inf) begin
         return b;
      end
      if (pa.is_zero && pb.is_zero) begin
         return {pa.sgn & pb.sgn, 31'd0};
      end
      if (pa.is_zero) begin
         return b;
      end
      if (pb.is_zero) begin
         return a;
      end
      if (pa.ex > pb.ex || (pa.ex == pb.ex && pa.man >= pb.man)) begin
         big = pa;
         sml = pb;
      end else begin
         big = pb;
         sml = pa;
      end
      d    = big.ex - sml.ex;
      mbig = big.man << 38;
      // Far below the rounding point the smaller operand only counts as sticky.
      msml = (d <= 38) ? (sml.man << (38 - d)) : 64'd1;
      sum  = (big.sgn == sml.sgn) ? (mbig + msml) : (mbig - msml);
      if (sum == 0) begin
         return FP_ZERO;
      end
      return round_pack(big.sgn, big.ex - 38, sum);
   endfunction

   function automatic logic [31:0] float_div(input logic [31:0] a, input logic [31:0] b);
      float_parts_type pa;
      float_parts_type pb;
      bit              sgn;
      longint unsigned quo;
      longint unsigned rem;
      pa  = split_float(a);
      pb  = split_float(b);
      sgn = pa.sgn ^ pb.sgn;
      if (pa.is_nan || pb.is_nan || (pa.is_zero && pb.is_zero) || (pa.is_inf && pb.is_inf))
      begin
         return FP_CANON;
      end
      if (pa.is_inf || pb.is_zero) begin
         return {sgn, 8'hFF, 23'd0};
      end
      if (pa.is_zero || pb.is_inf) begin
         return {sgn, 31'd0};
      end
      quo = (pa.man << 40) / pb.man;
      rem = (pa.man << 40) % pb.man;
      return round_pack(sgn, pa.ex - pb.ex - 40, quo | (rem != 0));
   endfunction

   function automatic logic [31:0] silu_by_exp(input logic [31:0] x);
      logic [31:0] t;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] p;
      logic [31:0] e;
      logic [23:0] sig;
      int          a_int;
      t = {~x[31], x[30:0]};
      a = float_add(float_add(float_mul(t, C_INV_LN2), C_MAGIC), C_NMAGIC);
      if (((a[30:23] == 8'hFF) && (a[22:0] != '0)) || (!a[31] && a[30:0] > MAG_127)) begin
         e = FP_INF;
      end else if (a[31] && a[30:0] > MAG_126) begin
         e = FP_ZERO;
      end else begin
         // a holds a whole number of magnitude at most 127.
         sig   = {1'b1, a[22:0]};
         a_int = (a[30:23] < 8'd127) ? 0 : int'(sig >> (150 - int'(a[30:23])));
         if (a[31]) begin
            a_int = -a_int;
         end
         b = float_add(t, float_mul(C_NEG_LN2, a));
         p = float_add(float_mul(C_H6, b), C_H5);
         p = float_add(float_mul(p, b), C_H4);
         p = float_add(float_mul(p, b), C_H3);
         p = float_add(float_mul(p, b), FP_HALF);
         p = float_add(float_mul(p, b), FP_ONE);
         p = float_add(float_mul(p, b), FP_ONE);
         e = float_mul({1'b0, 8'(a_int + 127), 23'd0}, p);
      end
      return float_div(x, float_add(e, FP_ONE));
   endfunction

   function automatic logic [31:0] silu_by_poly(input logic [31:0] x);
      logic [31:0] x2;
      logic [31:0] x3;
      logic [31:0] x5;
      logic [31:0] x7;
      logic [31:0] x9;
      logic [31:0] s;
      x2 = float_mul(x, x);
      x3 = float_mul(x, x2);
      x5 = float_mul(x3, x2);
      x7 = float_mul(x5, x2);
      x9 = float_mul(x7, x2);
      s  = float_add(FP_HALF, float_mul(FP_QUARTER, x));
      s  = float_add(s, float_mul(C_P3, x3));
      s  = float_add(s, float_mul(C_P5, x5));
      s  = float_add(s, float_mul(C_P7, x7));
      s  = float_add(s, float_mul(C_P9, x9));
      return float_mul(x, s);
   endfunction

   always @(posedge clock) begin
      silu_result_type want;
      logic [31:0]     y;
      if (reset) begin
         awaited_results.delete();
         poly_mode  <= 1'b0;
         fail_count <= 0;
      end else begin
         if (csr_write_enable) begin
            poly_mode <= csr_write_data;
         end
         if (req_valid && req_ready) begin
            y = poly_mode ? silu_by_poly(req_sample_bits) : silu_by_exp(req_sample_bits);
            if ((y[30:23] == 8'hFF) && (y[22:0] != '0)) begin
               y = FP_CANON;
            end
            want.result_bits = y;
            want.last_out    = req_last_in;
            awaited_results.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected response transaction: result_bits %h", rsp_result_bits);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_result_bits !== want.result_bits) begin
                  $error("result_bits: expected %h, got %h", want.result_bits,
                         rsp_result_bits);
                  fail_count <= fail_count + 1;
               end else if (rsp_last_out !== want.last_out) begin
                  $error("last_out: expected %b, got %b", want.last_out, rsp_last_out);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* test/silu_activation_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SiLU activation core testbench
// Drives directed corner samples and random samples through both sigmoid
// forms under changing sender and receiver idling; a checker alongside the
// core predicts and compares every response.
// ----------------------------------------------------------------------------
module silu_activation_core_test;
   import silu_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = PIPE_DEPTH + 30;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_sample_bits;
   logic        req_last_in;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_result_bits;
   logic        rsp_last_out;
   logic        csr_write_enable;
   logic        csr_write_data;
   int          fail_count;
   int          pending_count;
   int          sender_idle_pct;
   int          receiver_stall_pct;
   int          cycle_count;

   silu_activation_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_bits  (req_sample_bits),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_bits  (rsp_result_bits),
      .rsp_last_out     (rsp_last_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   silu_activation_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_bits  (req_sample_bits),
      .req_last_in      (req_last_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_bits  (rsp_result_bits),
      .rsp_last_out     (rsp_last_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Starts at a rising edge and returns at the edge that accepts the transaction.
   task automatic send_sample(input logic [31:0] bits, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_sample_bits <= bits;
      req_last_in     <= last;
      @(negedge clock);
      while (!req_ready) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic drain_pipeline;
      req_valid <= 1'b0;
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_method(input logic poly);
      csr_write_enable <= 1'b1;
      csr_write_data   <= poly;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly values near the interesting range, the rest any bit pattern.
   function automatic logic [31:0] random_sample;
      if ($urandom_range(3) == 0) begin
         return $urandom;
      end
      return {1'($urandom), 8'($urandom_range(100, 136)), 23'($urandom)};
   endfunction

   task automatic send_corners;
      logic [31:0] corners [24];
      corners = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                  32'h7FC0_0000, 32'hFF80_0001, 32'h0000_0001, 32'h807F_FFFF,
                  32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000, 32'hBF80_0000,
                  32'hC2B1_999A, 32'hC2AE_0000, 32'h42AE_0000, 32'h42B1_999A,
                  32'h42C8_0000, 32'hC2C8_0000, 32'h4120_0000, 32'hC120_0000,
                  32'h3A83_126F, 32'hAAAA_AAAA, 32'h5555_5555, 32'h4B40_0000};
      foreach (corners[i]) begin
         send_sample(corners[i], 1'(i & 1));
      end
   endtask

   task automatic run_phase(input logic poly, input int idle_pct, input int stall_pct,
                            input int count);
      drain_pipeline();
      write_method(poly);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         // Once, halfway through the phase, hold the sender until the pipeline has emptied.
         if (i == count / 2) begin
            req_valid <= 1'b0;
            while (pending_count != 0) begin
               @(posedge clock);
            end
         end
         send_sample(random_sample(), 1'($urandom));
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_sample_bits    = '0;
      req_last_in        = 1'b0;
      csr_write_enable   = 1'b0;
      csr_write_data     = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_corners();
      drain_pipeline();
      write_method(1'b1);
      send_corners();

      run_phase(1'b0, 0, 0, 170);
      run_phase(1'b1, 65, 0, 170);
      run_phase(1'b0, 0, 65, 170);
      run_phase(1'b1, 31, 31, 170);
      drain_pipeline();

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/silu_pkg.sv
sv/silu_fp_step.sv
sv/silu_fp_div.sv
sv/silu_activation_core.sv
test/silu_activation_checker.sv
test/silu_activation_core_test.sv
